[hdl/rrbc_pkg.sv]
// Shared types, codes and constants of the ROM/RAM bank controller.
`default_nettype none

package rrbc_pkg;

	localparam int MAX_ROM_BANKS = 128;
	localparam int MAX_RAM_BANKS = 4;

	// Result target codes.
	localparam logic [2:0] TGT_NONE    = 3'd0;
	localparam logic [2:0] TGT_BOOTROM = 3'd1;
	localparam logic [2:0] TGT_ROM     = 3'd2;
	localparam logic [2:0] TGT_RAM_RD  = 3'd3;
	localparam logic [2:0] TGT_RAM_WR  = 3'd4;
	localparam logic [2:0] TGT_FF      = 3'd5;
	localparam logic [2:0] TGT_ZERO    = 3'd6;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_ROM_COUNT = 2'd0;
	localparam logic [1:0] REG_RAM_COUNT = 2'd1;
	localparam logic [1:0] REG_BOOT_EN   = 2'd2;

	// One dividend bit is taken into the remainder per step over the five bank bits.
	localparam logic [2:0] DIV_STEPS = 3'd5;

	typedef struct packed {
		logic        command;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [20:0] mapped_address;
		logic [7:0]  write_data;
	} rsp_item_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [7:0]  wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic latch_item;
		logic exec;
		logic div_start;
		logic div_step;
		logic div_done;
	} dp_cmd_t;

	typedef struct packed {
		logic bank_write;
	} dp_status_t;

endpackage

`default_nettype wire

[hdl/rrbc_ctrl.sv]
// Controller state machine: item acceptance, result slot and bank divide sequencing.
`default_nettype none

module rrbc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	input  wire rrbc_pkg::dp_status_t status,
	output rrbc_pkg::dp_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	localparam logic [2:0] DIV_STEPS_M1 = rrbc_pkg::DIV_STEPS - 3'd1;

	logic [1:0] state_q, state_d;
	logic [2:0] count_q;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch_item = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					cmd.exec = 1'b1;
					if (status.bank_write) begin
						cmd.div_start = 1'b1;
						state_d = ST_DIV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (count_q == DIV_STEPS_M1) begin
					cmd.div_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) begin
				count_q <= '0;
			end else if (cmd.div_step) begin
				count_q <= count_q + 3'd1;
			end
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/rrbc_dp.sv]
// Datapath: configuration and bank registers, address mapping, remainder unit, result register.
`default_nettype none

module rrbc_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rrbc_pkg::req_item_t  req,
	output rrbc_pkg::rsp_item_t       rsp,
	input  wire rrbc_pkg::cfg_wr_t    cfg,
	input  wire logic [1:0]           rd_index,
	output logic [31:0]               rd_data,
	input  wire rrbc_pkg::dp_cmd_t    cmd,
	output rrbc_pkg::dp_status_t      status
);

	logic [7:0] rom_count_q;
	logic [2:0] ram_count_q;
	logic       boot_en_q;

	logic [6:0] rom_bank_q;
	logic [1:0] ram_bank_q;
	logic       ram_en_q;
	logic       mode_q;

	rrbc_pkg::req_item_t item_q;
	rrbc_pkg::rsp_item_t rsp_q;
	rrbc_pkg::rsp_item_t result;

	logic [7:0] rom_eff;
	logic [2:0] ram_eff;
	logic [4:0] bank_sel;
	logic [4:0] div_bits_q;
	logic [6:0] rem_q;
	logic [7:0] rem_sh;
	logic [7:0] rem_next;
	logic [1:0] ram_mod;

	logic [15:0] a;
	logic        in_ram_win;

	assign a = item_q.bus_address;
	assign in_ram_win = (a[15:13] == 3'b101);

	always_comb begin
		if (rom_count_q < 8'd2) begin
			rom_eff = 8'd2;
		end else if (rom_count_q > 8'(rrbc_pkg::MAX_ROM_BANKS)) begin
			rom_eff = 8'(rrbc_pkg::MAX_ROM_BANKS);
		end else begin
			rom_eff = rom_count_q;
		end
		if (ram_count_q < 3'd1) begin
			ram_eff = 3'd1;
		end else if (ram_count_q > 3'(rrbc_pkg::MAX_RAM_BANKS)) begin
			ram_eff = 3'(rrbc_pkg::MAX_RAM_BANKS);
		end else begin
			ram_eff = ram_count_q;
		end
	end

	// Two-bit value reduced by a bank count of one to four.
	always_comb begin
		unique case (ram_eff)
			3'd1: ram_mod = 2'd0;
			3'd2: ram_mod = {1'b0, item_q.bus_data[0]};
			3'd3: ram_mod = (item_q.bus_data[1:0] == 2'd3) ? 2'd0 : item_q.bus_data[1:0];
			default: ram_mod = item_q.bus_data[1:0];
		endcase
	end

	assign bank_sel = (item_q.bus_data[4:0] == 5'd0) ? 5'd1 : item_q.bus_data[4:0];
	assign status.bank_write = (item_q.command == rrbc_pkg::CMD_WRITE) && (a[15:13] == 3'b001);

	// Restoring remainder step; the running remainder stays below the bank count.
	assign rem_sh = {rem_q, div_bits_q[4]};
	assign rem_next = (rem_sh >= rom_eff) ? (rem_sh - rom_eff) : rem_sh;

	always_comb begin
		result = '0;
		if (item_q.command == rrbc_pkg::CMD_READ) begin
			if (a <= 16'h00FF && boot_en_q) begin
				result.target = rrbc_pkg::TGT_BOOTROM;
				result.mapped_address = {5'd0, a};
			end else if (a[15:14] == 2'b00) begin
				result.target = rrbc_pkg::TGT_ROM;
				result.mapped_address = {5'd0, a};
			end else if (a[15:14] == 2'b01) begin
				result.target = rrbc_pkg::TGT_ROM;
				result.mapped_address = {rom_bank_q, a[13:0]};
			end else if (in_ram_win) begin
				if (ram_en_q) begin
					result.target = rrbc_pkg::TGT_RAM_RD;
					result.mapped_address = {6'd0, ram_bank_q, a[12:0]};
				end else begin
					result.target = rrbc_pkg::TGT_FF;
				end
			end else begin
				result.target = rrbc_pkg::TGT_ZERO;
			end
		end else if (in_ram_win && ram_en_q) begin
			result.target = rrbc_pkg::TGT_RAM_WR;
			result.mapped_address = {6'd0, ram_bank_q, a[12:0]};
			result.write_data = item_q.bus_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_count_q <= 8'd2;
			ram_count_q <= 3'd1;
			boot_en_q <= 1'b1;
			rom_bank_q <= 7'd1;
			ram_bank_q <= 2'd0;
			ram_en_q <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			if (cfg.we) begin
				unique case (cfg.index)
					rrbc_pkg::REG_ROM_COUNT: rom_count_q <= cfg.wdata;
					rrbc_pkg::REG_RAM_COUNT: ram_count_q <= cfg.wdata[2:0];
					rrbc_pkg::REG_BOOT_EN:   boot_en_q <= cfg.wdata[0];
					default: ;
				endcase
			end
			if (cmd.exec && item_q.command == rrbc_pkg::CMD_WRITE) begin
				unique case (a[15:13])
					3'b000: ram_en_q <= (item_q.bus_data[3:0] == 4'hA);
					3'b010: begin
						if (!mode_q) begin
							ram_bank_q <= ram_mod;
						end else begin
							rom_bank_q <= {item_q.bus_data[1:0], rom_bank_q[4:0]};
						end
					end
					3'b011: mode_q <= item_q.bus_data[0];
					default: ;
				endcase
			end
			if (cmd.div_done) begin
				rom_bank_q <= rem_next[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			item_q <= req;
		end
		if (cmd.exec) begin
			rsp_q <= result;
		end
		if (cmd.div_start) begin
			div_bits_q <= bank_sel;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			div_bits_q <= {div_bits_q[3:0], 1'b0};
			rem_q <= rem_next[6:0];
		end
	end

	assign rsp = rsp_q;

	always_comb begin
		unique case (rd_index)
			rrbc_pkg::REG_ROM_COUNT: rd_data = {24'd0, rom_count_q};
			rrbc_pkg::REG_RAM_COUNT: rd_data = {29'd0, ram_count_q};
			rrbc_pkg::REG_BOOT_EN:   rd_data = {31'd0, boot_en_q};
			default:                 rd_data = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[hdl/rom_ram_bank_controller_top.sv]
// Top level of the ROM/RAM bank controller: channels, register port, controller and datapath.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   req      | req_valid, req_stall, req                | in
//   rsp      | rsp_valid, rsp_stall, rsp                | out
//   apb      | psel penable pwrite paddr pwdata prdata  | register port
//
// An item is latched while the block is idle and its result is loaded into the
// output register once the output slot is free. A write to the low ROM bank
// register also runs the bank remainder unit, one bit per cycle over five bits,
// before the next item is taken. Reset leaves the bank registers at their
// initial values and the block ready at once. A stalled result holds the next item.
`default_nettype none

module rom_ram_bank_controller_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire rrbc_pkg::req_item_t  req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rrbc_pkg::rsp_item_t       rsp,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	rrbc_pkg::dp_cmd_t    cmd;
	rrbc_pkg::dp_status_t status;
	rrbc_pkg::cfg_wr_t    cfg;

	assign pready = 1'b1;
	assign cfg = '{we: psel && penable && pwrite, index: paddr[3:2], wdata: pwdata[7:0]};

	rrbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rrbc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.rd_index (paddr[3:2]),
		.rd_data  (prdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

`default_nettype wire

[sim/rrbc_translation_monitor.sv]
// Monitor that predicts each bus access translation of the bank controller and checks the results.
module rrbc_translation_monitor
	import rrbc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  req_item_t        req,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  rsp_item_t        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               outstanding
);

	localparam int REPORT_LIMIT = 10;

	// Shadow copy of the register file and the banking state.
	logic [7:0] rom_count;
	logic [2:0] ram_count;
	logic       boot_en;
	logic [6:0] rom_bank;
	logic [1:0] ram_bank;
	logic       ram_en;
	logic       adv_mode;

	rsp_item_t translations[$];

	function automatic rsp_item_t translate_access(input req_item_t it);
		rsp_item_t r;
		logic [15:0] a;
		int rom_div;
		int ram_div;
		int bank;
		r = '0;
		a = it.bus_address;
		// Out-of-range bank counts are clamped before the remainder is taken.
		rom_div = (rom_count < 2) ? 2 :
			((int'(rom_count) > MAX_ROM_BANKS) ? MAX_ROM_BANKS : int'(rom_count));
		ram_div = (ram_count < 1) ? 1 :
			((int'(ram_count) > MAX_RAM_BANKS) ? MAX_RAM_BANKS : int'(ram_count));
		if (it.command == CMD_READ) begin
			if (a <= 16'h00FF && boot_en) begin
				r.target = TGT_BOOTROM;
				r.mapped_address = 21'(a);
			end else if (a < 16'h4000) begin
				r.target = TGT_ROM;
				r.mapped_address = 21'(a);
			end else if (a < 16'h8000) begin
				r.target = TGT_ROM;
				r.mapped_address = {rom_bank, a[13:0]};
			end else if (a >= 16'hA000 && a < 16'hC000) begin
				if (ram_en) begin
					r.target = TGT_RAM_RD;
					r.mapped_address = {6'd0, ram_bank, a[12:0]};
				end else begin
					r.target = TGT_FF;
				end
			end else begin
				r.target = TGT_ZERO;
			end
		end else begin
			if (a < 16'h2000) begin
				ram_en = (it.bus_data[3:0] == 4'hA);
			end else if (a < 16'h4000) begin
				bank = (it.bus_data[4:0] == 5'd0) ? 1 : int'(it.bus_data[4:0]);
				rom_bank = 7'(bank % rom_div);
			end else if (a < 16'h6000) begin
				if (!adv_mode)
					ram_bank = 2'(int'(it.bus_data[1:0]) % ram_div);
				else
					rom_bank = {it.bus_data[1:0], rom_bank[4:0]};
			end else if (a < 16'h8000) begin
				adv_mode = it.bus_data[0];
			end else if (a >= 16'hA000 && a < 16'hC000 && ram_en) begin
				r.target = TGT_RAM_WR;
				r.mapped_address = {6'd0, ram_bank, a[12:0]};
				r.write_data = it.bus_data;
			end
		end
		return r;
	endfunction

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rom_count = 8'd2;
			ram_count = 3'd1;
			boot_en = 1'b1;
			rom_bank = 7'd1;
			ram_bank = 2'd0;
			ram_en = 1'b0;
			adv_mode = 1'b0;
			translations.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			// Results are checked before this edge's item is predicted, so a result
			// can never be matched against an access that was taken at the same edge.
			if (rsp_valid && !rsp_stall) begin
				if (translations.size() == 0) begin
					note_failure($sformatf("result with nothing expected: target %0d address %0h data %0h",
						rsp.target, rsp.mapped_address, rsp.write_data));
				end else begin
					want = translations.pop_front();
					if (rsp.target !== want.target)
						note_failure($sformatf("target: expected %0d, got %0d",
							want.target, rsp.target));
					if (rsp.mapped_address !== want.mapped_address)
						note_failure($sformatf("mapped_address: expected %0h, got %0h",
							want.mapped_address, rsp.mapped_address));
					if (rsp.write_data !== want.write_data)
						note_failure($sformatf("write_data: expected %0h, got %0h",
							want.write_data, rsp.write_data));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_ROM_COUNT: rom_count = pwdata[7:0];
					REG_RAM_COUNT: ram_count = pwdata[2:0];
					REG_BOOT_EN:   boot_en = pwdata[0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				translations.push_back(translate_access(req));
			outstanding = translations.size();
		end
	end

endmodule

[sim/tb_rom_ram_bank_controller_top.sv]
// Testbench top of the ROM/RAM bank controller: clock, reset, stimulus and verdict.
module tb_rom_ram_bank_controller_top;
	import rrbc_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int SETTLE_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_item_t   req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_item_t   rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int snd_idle = 0;
	int rcv_idle = 0;
	int quiet_cycles = 0;
	int errors;
	int outstanding;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rom_ram_bank_controller_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rrbc_translation_monitor monitor (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(errors), .outstanding(outstanding)
	);

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
	end

	// Any handshake on either channel or the register port counts as progress.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
			$display("[rom_ram_bank_controller_top] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic req_item_t access(input logic cmd, input logic [15:0] a,
			input logic [7:0] d);
		req_item_t it;
		it.command = cmd;
		it.bus_address = a;
		it.bus_data = d;
		return it;
	endfunction

	// Mostly accesses aimed at the register and memory windows, with some fully random ones.
	function automatic req_item_t random_access();
		int k;
		logic [7:0] d;
		k = $urandom_range(0, 99);
		d = 8'($urandom_range(0, 255));
		if (k < 10)
			return access(CMD_READ, 16'($urandom_range(0, 16'h00FF)), d);
		else if (k < 20)
			return access(CMD_READ, 16'($urandom_range(0, 16'h3FFF)), d);
		else if (k < 35)
			return access(CMD_READ, 16'($urandom_range(16'h4000, 16'h7FFF)), d);
		else if (k < 50)
			return access(CMD_READ, 16'($urandom_range(16'hA000, 16'hBFFF)), d);
		else if (k < 55)
			return access(CMD_READ, 16'($urandom_range(0, 16'hFFFF)), d);
		else if (k < 62) begin
			if ($urandom_range(0, 9) < 6)
				d[3:0] = 4'hA;
			return access(CMD_WRITE, 16'($urandom_range(0, 16'h1FFF)), d);
		end else if (k < 69)
			return access(CMD_WRITE, 16'($urandom_range(16'h2000, 16'h3FFF)), d);
		else if (k < 75)
			return access(CMD_WRITE, 16'($urandom_range(16'h4000, 16'h5FFF)), d);
		else if (k < 80)
			return access(CMD_WRITE, 16'($urandom_range(16'h6000, 16'h7FFF)), d);
		else if (k < 93)
			return access(CMD_WRITE, 16'($urandom_range(16'hA000, 16'hBFFF)), d);
		else
			return access(CMD_WRITE, 16'($urandom_range(0, 16'hFFFF)), d);
	endfunction

	// Entered and left at a falling edge; valid stays high into the next item when no gap is drawn.
	task automatic send(input req_item_t it);
		while ($urandom_range(0, 99) < snd_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// A bank remainder can still be running after its result has left, so the block
	// must also be ready again before the registers are touched.
	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0 || req_stall)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] rom_n;
		logic [2:0] ram_n;
		logic       boot_n;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		snd_idle = 23;
		rcv_idle = 66;

		// Directed accesses with the registers at their reset values.
		send(access(CMD_READ,  16'h0000, 8'h00));
		send(access(CMD_READ,  16'h00FF, 8'hFF));
		send(access(CMD_READ,  16'h0100, 8'h00));
		send(access(CMD_READ,  16'h3FFF, 8'h00));
		send(access(CMD_READ,  16'h4000, 8'h00));
		send(access(CMD_READ,  16'h7FFF, 8'h00));
		send(access(CMD_READ,  16'hA000, 8'h00));
		send(access(CMD_READ,  16'h8000, 8'h00));
		send(access(CMD_READ,  16'hFFFF, 8'h00));
		send(access(CMD_READ,  16'hC000, 8'h00));
		send(access(CMD_WRITE, 16'h0000, 8'h0A));
		send(access(CMD_READ,  16'hBFFF, 8'h00));
		send(access(CMD_WRITE, 16'hA000, 8'hFF));
		send(access(CMD_WRITE, 16'hBFFF, 8'h00));
		send(access(CMD_WRITE, 16'h2000, 8'h00));
		send(access(CMD_WRITE, 16'h3FFF, 8'hFF));
		send(access(CMD_WRITE, 16'h4000, 8'h03));
		send(access(CMD_WRITE, 16'h6000, 8'h01));
		send(access(CMD_WRITE, 16'h5FFF, 8'h02));
		send(access(CMD_READ,  16'h4001, 8'h00));
		send(access(CMD_WRITE, 16'h7FFF, 8'hFE));
		send(access(CMD_WRITE, 16'h8000, 8'h55));
		send(access(CMD_WRITE, 16'hFFFF, 8'hAA));
		send(access(CMD_WRITE, 16'h1FFF, 8'h1B));
		send(access(CMD_READ,  16'hA123, 8'h00));

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				snd_idle = 66;
				rcv_idle = 23;
			end else if (p == 4) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			if (p > 0) begin
				// Out-of-range counts on both sides are part of the sweep.
				case (p)
					1: begin rom_n = 8'd0;   ram_n = 3'd0; boot_n = 1'b0; end
					2: begin rom_n = 8'd255; ram_n = 3'd7; boot_n = 1'b1; end
					3: begin rom_n = 8'd128; ram_n = 3'd4; boot_n = 1'b0; end
					4: begin rom_n = 8'd3;   ram_n = 3'd3; boot_n = 1'b1; end
					default: begin
						rom_n = 8'($urandom_range(0, 255));
						ram_n = 3'($urandom_range(0, 7));
						boot_n = 1'($urandom_range(0, 1));
					end
				endcase
				drain();
				write_reg(REG_ROM_COUNT, {24'd0, rom_n});
				write_reg(REG_RAM_COUNT, {29'd0, ram_n});
				write_reg(REG_BOOT_EN, {31'd0, boot_n});
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 49) == 0)
					drain();
				send(random_access());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("[rom_ram_bank_controller_top] OK");
		else
			$display("[rom_ram_bank_controller_top] ERROR");
		$finish;
	end

endmodule

[filelist.f]
hdl/rrbc_pkg.sv
hdl/rrbc_ctrl.sv
hdl/rrbc_dp.sv
hdl/rom_ram_bank_controller_top.sv
sim/rrbc_translation_monitor.sv
sim/tb_rom_ram_bank_controller_top.sv
